/* rtl/core/pec_pkg.sv */
package pec_pkg;

  // Field widths.
  localparam int POS_W            = 27;
  localparam int YAW_W            = 19;
  localparam int INV_W            = 23;
  localparam int MIN_W            = 7;
  localparam int TIME_W           = 32;
  localparam int PEN_W            = 13;
  localparam int FEAT_PORT_W      = 64;
  localparam int FEATURE_BITS_DEF = 64;
  localparam int FRAC_W           = 16;

  // Distance datapath widths.
  localparam int SQ_W   = 2 * POS_W;
  localparam int RAD_W  = SQ_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int PROD_W = ROOT_W + INV_W;
  localparam int PATH_W = PROD_W - FRAC_W;
  localparam int YT_W   = YAW_W + INV_W - FRAC_W;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [YAW_W-1:0] TWO_PI_Q16     = YAW_W'(411775);
  localparam logic [PEN_W-1:0] PEN_MAX        = PEN_W'(8191);
  localparam logic [INV_W-1:0] INV_SPEED_RST  = INV_W'(65536);
  localparam logic [INV_W-1:0] INV_YAW_RST    = INV_W'(65536);
  localparam logic [MIN_W-1:0] MIN_SHARED_RST = MIN_W'(10);

  typedef enum logic [1:0] {
    REG_INV_SPEED  = 2'd0,
    REG_INV_YAW    = 2'd1,
    REG_MIN_SHARED = 2'd2
  } reg_idx_t;

  // Values that ride alongside the square root pipeline.
  typedef struct packed {
    logic [YT_W-1:0]  t_yaw;
    logic             localizable;
    logic [PEN_W-1:0] penalty;
  } side_t;

  typedef struct packed {
    logic [TIME_W-1:0] travel_time;
    logic              localizable;
    logic [PEN_W-1:0]  penalty;
  } res_t;

endpackage

/* rtl/core/pose_edge_cost_evaluator.sv */
// Throughput: one transaction per cycle, sustained, while out_ready stays high.
// Depth: 4 front stages, a 28-stage square root (one root bit per stage), 1 multiply stage,
// and the output register. Reset (rst_n low, synchronous) clears all valid bits and the skid
// register and loads the configuration registers with their reset values; no clearing pass.
module pose_edge_cost_evaluator #(
  parameter int FEATURE_BITS = pec_pkg::FEATURE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pec_pkg::POS_W-1:0]      in_pos_a_x,
  input  logic signed [pec_pkg::POS_W-1:0]      in_pos_a_y,
  input  logic signed [pec_pkg::POS_W-1:0]      in_pos_a_z,
  input  logic signed [pec_pkg::YAW_W-1:0]      in_yaw_a,
  input  logic signed [pec_pkg::POS_W-1:0]      in_pos_b_x,
  input  logic signed [pec_pkg::POS_W-1:0]      in_pos_b_y,
  input  logic signed [pec_pkg::POS_W-1:0]      in_pos_b_z,
  input  logic signed [pec_pkg::YAW_W-1:0]      in_yaw_b,
  input  logic        [pec_pkg::FEAT_PORT_W-1:0] in_features_a,
  input  logic        [pec_pkg::FEAT_PORT_W-1:0] in_features_b,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [pec_pkg::TIME_W-1:0]     out_travel_time,
  output logic                                  out_localizable,
  output logic        [pec_pkg::PEN_W-1:0]      out_feature_penalty,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [pec_pkg::ADDR_W-1:0]     paddr,
  input  logic        [pec_pkg::DATA_W-1:0]     pwdata,
  output logic        [pec_pkg::DATA_W-1:0]     prdata,
  output logic                                  pready
);

  localparam int INV_W  = pec_pkg::INV_W;
  localparam int MIN_W  = pec_pkg::MIN_W;
  localparam int PROD_W = pec_pkg::PROD_W;
  localparam int PATH_W = pec_pkg::PATH_W;
  localparam int TIME_W = pec_pkg::TIME_W;
  localparam int DATA_W = pec_pkg::DATA_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never waits, so pready is tied high and a
  // write lands on the access cycle. Registers sit at byte offsets 0, 4 and 8;
  // only paddr[3:2] is decoded, so a write with paddr[3:2] of 3 is dropped.
  // ---------------------------------------------------------------------------
  logic [INV_W-1:0]  inv_speed_r, inv_yaw_r;
  logic [MIN_W-1:0]  min_shared_r;
  pec_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = pec_pkg::reg_idx_t'(paddr[pec_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_speed_r  <= pec_pkg::INV_SPEED_RST;
      inv_yaw_r    <= pec_pkg::INV_YAW_RST;
      min_shared_r <= pec_pkg::MIN_SHARED_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pec_pkg::REG_INV_SPEED:  inv_speed_r  <= pwdata[INV_W-1:0];
        pec_pkg::REG_INV_YAW:    inv_yaw_r    <= pwdata[INV_W-1:0];
        pec_pkg::REG_MIN_SHARED: min_shared_r <= pwdata[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pec_pkg::REG_INV_SPEED:  prdata = DATA_W'(inv_speed_r);
      pec_pkg::REG_INV_YAW:    prdata = DATA_W'(inv_yaw_r);
      pec_pkg::REG_MIN_SHARED: prdata = DATA_W'(min_shared_r);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance. Every stage moves together whenever the skid register is
  // empty. A result that leaves the pipeline while the output register is held
  // by the consumer parks in the skid register, and only then does the whole
  // pipeline freeze. Because the freeze comes from a register, in_ready has no
  // combinational path from out_ready, and the pipeline keeps taking
  // transactions while one finished result waits at the output.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_vld_r, skid_vld_nxt;

  assign en       = !skid_vld_r;
  assign in_ready = rst_n && en;

  // Front end: coordinate differences and squares, yaw wrap and yaw time,
  // feature counts and penalty. Four stages.
  logic             fr_vld;
  logic [pec_pkg::RAD_W-1:0] fr_rad;
  pec_pkg::side_t   fr_side;

  pec_front #(
    .FEATURE_BITS (FEATURE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (in_valid && in_ready),
    .pos_a_x    (in_pos_a_x),
    .pos_a_y    (in_pos_a_y),
    .pos_a_z    (in_pos_a_z),
    .yaw_a      (in_yaw_a),
    .pos_b_x    (in_pos_b_x),
    .pos_b_y    (in_pos_b_y),
    .pos_b_z    (in_pos_b_z),
    .yaw_b      (in_yaw_b),
    .features_a (in_features_a),
    .features_b (in_features_b),
    .inv_yaw    (inv_yaw_r),
    .min_shared (min_shared_r),
    .out_vld    (fr_vld),
    .out_rad    (fr_rad),
    .out_side   (fr_side)
  );

  // Floor square root of the summed squares gives the distance in Q16.
  // The yaw time, localizability and penalty travel along as side data.
  logic                       sq_vld;
  logic [pec_pkg::ROOT_W-1:0] sq_root;
  pec_pkg::side_t             sq_side;

  pec_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_rad   (fr_rad),
    .in_side  (fr_side),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // Distance times the reciprocal of top speed, registered before the compare.
  logic              prod_vld_r;
  logic [PROD_W-1:0] prod_r;
  pec_pkg::side_t    prod_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else if (en) begin
      prod_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r      <= PROD_W'(sq_root) * PROD_W'(inv_speed_r);
      prod_side_r <= sq_side;
    end
  end

  // Travel time is the larger of the two time terms, saturated to 32 bits.
  // Only the path term can exceed the output range.
  logic [PATH_W-1:0] t_path, t_yaw_ext, t_max;
  pec_pkg::res_t     res_nxt;

  always_comb begin
    t_path    = prod_r[PROD_W-1:pec_pkg::FRAC_W];
    t_yaw_ext = PATH_W'(prod_side_r.t_yaw);
    t_max     = (t_path > t_yaw_ext) ? t_path : t_yaw_ext;
    if (|t_max[PATH_W-1:TIME_W]) begin
      res_nxt.travel_time = '1;
    end else begin
      res_nxt.travel_time = t_max[TIME_W-1:0];
    end
    res_nxt.localizable = prod_side_r.localizable;
    res_nxt.penalty     = prod_side_r.penalty;
  end

  // ---------------------------------------------------------------------------
  // Output register and skid register. When the output register is free or
  // being emptied, it takes the parked result first, otherwise whatever leaves
  // the pipeline. When it is held, a result leaving the pipeline is parked.
  // ---------------------------------------------------------------------------
  logic          out_vld_r, out_vld_nxt;
  pec_pkg::res_t out_res_r, out_res_nxt;
  pec_pkg::res_t skid_res_r, skid_res_nxt;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = prod_vld_r;
        out_res_nxt = res_nxt;
      end
    end else if (en && prod_vld_r) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid           = out_vld_r;
  assign out_travel_time     = out_res_r.travel_time;
  assign out_localizable     = out_res_r.localizable;
  assign out_feature_penalty = out_res_r.penalty;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // A parked result always has a result ahead of it in the output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register holds a result while the output register is empty");

  // The skid register fills only when a result leaves the pipeline into a held output.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_ready && prod_vld_r))
    else $error("skid register filled without a stalled output");

  // A parked result moves to the output as soon as the output transaction completes.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ready && skid_vld_r) |=> (out_vld_r && !skid_vld_r))
    else $error("parked result not moved to the output register");

  // While the pipeline is frozen, the result at its end is kept.
  a_frozen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && prod_vld_r) |=> prod_vld_r)
    else $error("result lost from a frozen pipeline");

endmodule

/* rtl/core/pec_front.sv */
module pec_front #(
  parameter int FEATURE_BITS = pec_pkg::FEATURE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_vld,
  input  logic signed [pec_pkg::POS_W-1:0]      pos_a_x,
  input  logic signed [pec_pkg::POS_W-1:0]      pos_a_y,
  input  logic signed [pec_pkg::POS_W-1:0]      pos_a_z,
  input  logic signed [pec_pkg::YAW_W-1:0]      yaw_a,
  input  logic signed [pec_pkg::POS_W-1:0]      pos_b_x,
  input  logic signed [pec_pkg::POS_W-1:0]      pos_b_y,
  input  logic signed [pec_pkg::POS_W-1:0]      pos_b_z,
  input  logic signed [pec_pkg::YAW_W-1:0]      yaw_b,
  input  logic        [pec_pkg::FEAT_PORT_W-1:0] features_a,
  input  logic        [pec_pkg::FEAT_PORT_W-1:0] features_b,
  input  logic        [pec_pkg::INV_W-1:0]      inv_yaw,
  input  logic        [pec_pkg::MIN_W-1:0]      min_shared,
  output logic                                  out_vld,
  output logic        [pec_pkg::RAD_W-1:0]      out_rad,
  output pec_pkg::side_t                        out_side
);

  localparam int POS_W = pec_pkg::POS_W;
  localparam int YAW_W = pec_pkg::YAW_W;
  localparam int MIN_W = pec_pkg::MIN_W;
  localparam int SQ_W  = pec_pkg::SQ_W;
  localparam int RAD_W = pec_pkg::RAD_W;
  localparam int YP_W  = pec_pkg::YAW_W + pec_pkg::INV_W;
  localparam int NCH   = (FEATURE_BITS + 7) / 8;
  localparam int CW    = NCH * 8;
  localparam int CNT_W = $clog2(FEATURE_BITS + 1);
  localparam int PSQ_W = 2 * MIN_W;

  function automatic logic [POS_W-1:0] abs_pos(input logic signed [POS_W:0] d);
    logic [POS_W:0] n;
    n = d[POS_W] ? -d : d;
    return n[POS_W-1:0];
  endfunction

  function automatic logic [YAW_W-1:0] abs_yaw(input logic signed [YAW_W:0] d);
    logic [YAW_W:0] n;
    n = d[YAW_W] ? -d : d;
    return n[YAW_W-1:0];
  endfunction

  // Stage 1: signed differences and per-byte feature counts.
  logic                    v1_r;
  logic signed [POS_W:0]   dx_r, dy_r, dz_r;
  logic signed [YAW_W:0]   dyaw_r;
  logic [3:0]              sh_r [NCH];
  logic [3:0]              df_r [NCH];
  logic [3:0]              sh_nxt [NCH];
  logic [3:0]              df_nxt [NCH];
  logic [CW-1:0]           f_and, f_xor;

  assign f_and = CW'(features_a[FEATURE_BITS-1:0] & features_b[FEATURE_BITS-1:0]);
  assign f_xor = CW'(features_a[FEATURE_BITS-1:0] ^ features_b[FEATURE_BITS-1:0]);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sh_nxt[c] = '0;
      df_nxt[c] = '0;
      for (int b = 0; b < 8; b++) begin
        sh_nxt[c] = sh_nxt[c] + 4'(f_and[c*8+b]);
        df_nxt[c] = df_nxt[c] + 4'(f_xor[c*8+b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= (POS_W+1)'(pos_a_x) - (POS_W+1)'(pos_b_x);
      dy_r   <= (POS_W+1)'(pos_a_y) - (POS_W+1)'(pos_b_y);
      dz_r   <= (POS_W+1)'(pos_a_z) - (POS_W+1)'(pos_b_z);
      dyaw_r <= (YAW_W+1)'(yaw_a) - (YAW_W+1)'(yaw_b);
      sh_r   <= sh_nxt;
      df_r   <= df_nxt;
    end
  end

  // Stage 2: magnitudes and total feature counts.
  logic             v2_r;
  logic [POS_W-1:0] ax_r, ay_r, az_r;
  logic [YAW_W-1:0] ayaw_r;
  logic [CNT_W-1:0] sh_tot_r, df_tot_r;
  logic [CNT_W-1:0] sh_tot_nxt, df_tot_nxt;

  always_comb begin
    sh_tot_nxt = '0;
    df_tot_nxt = '0;
    for (int c = 0; c < NCH; c++) begin
      sh_tot_nxt = sh_tot_nxt + CNT_W'(sh_r[c]);
      df_tot_nxt = df_tot_nxt + CNT_W'(df_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r     <= abs_pos(dx_r);
      ay_r     <= abs_pos(dy_r);
      az_r     <= abs_pos(dz_r);
      ayaw_r   <= abs_yaw(dyaw_r);
      sh_tot_r <= sh_tot_nxt;
      df_tot_r <= df_tot_nxt;
    end
  end

  // Stage 3: squares, yaw wrap, threshold compares.
  logic             v3_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r, sqz_r;
  logic [YAW_W-1:0] yw_r, yw_nxt, yaw_rest;
  logic             loc_r;
  logic [MIN_W-1:0] short_r, short_nxt;

  always_comb begin
    yaw_rest = pec_pkg::TWO_PI_Q16 - ayaw_r;
    if (ayaw_r > pec_pkg::TWO_PI_Q16) begin
      yw_nxt = '0;
    end else if (yaw_rest < ayaw_r) begin
      yw_nxt = yaw_rest;
    end else begin
      yw_nxt = ayaw_r;
    end
    if (MIN_W'(df_tot_r) < min_shared) begin
      short_nxt = min_shared - MIN_W'(df_tot_r);
    end else begin
      short_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r   <= SQ_W'(ax_r) * SQ_W'(ax_r);
      sqy_r   <= SQ_W'(ay_r) * SQ_W'(ay_r);
      sqz_r   <= SQ_W'(az_r) * SQ_W'(az_r);
      yw_r    <= yw_nxt;
      loc_r   <= (MIN_W'(sh_tot_r) > min_shared);
      short_r <= short_nxt;
    end
  end

  // Stage 4: radicand, yaw time and saturated penalty.
  logic                v4_r;
  logic [RAD_W-1:0]    rad_r;
  pec_pkg::side_t      side_r, side_nxt;
  logic [YP_W-1:0]     yaw_prod;
  logic [PSQ_W-1:0]    pen_sq;

  always_comb begin
    yaw_prod             = YP_W'(yw_r) * YP_W'(inv_yaw);
    pen_sq               = PSQ_W'(short_r) * PSQ_W'(short_r);
    side_nxt.t_yaw       = yaw_prod[YP_W-1:pec_pkg::FRAC_W];
    side_nxt.localizable = loc_r;
    if (pen_sq > PSQ_W'(pec_pkg::PEN_MAX)) begin
      side_nxt.penalty = pec_pkg::PEN_MAX;
    end else begin
      side_nxt.penalty = pec_pkg::PEN_W'(pen_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= RAD_W'(sqx_r) + RAD_W'(sqy_r) + RAD_W'(sqz_r);
      side_r <= side_nxt;
    end
  end

  assign out_vld  = v4_r;
  assign out_rad  = rad_r;
  assign out_side = side_r;

endmodule

/* rtl/core/pec_isqrt.sv */
module pec_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [pec_pkg::RAD_W-1:0]    in_rad,
  input  pec_pkg::side_t               in_side,
  output logic                         out_vld,
  output logic [pec_pkg::ROOT_W-1:0]   out_root,
  output pec_pkg::side_t               out_side
);

  // Digit-by-digit square root: each stage settles one root bit.
  localparam int N     = pec_pkg::ROOT_W;
  localparam int RAD_W = pec_pkg::RAD_W;
  localparam int REM_W = pec_pkg::REM_W;

  logic             vld_r  [1:N];
  logic [N-1:0]     root_r [1:N];
  pec_pkg::side_t   side_r [1:N];
  logic [REM_W-1:0] rem_r  [1:N-1];
  logic [RAD_W-1:0] x_r    [1:N-1];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic             vld_in;
    logic [REM_W-1:0] rem_in, rem_sh, trial, rem_nxt;
    logic [N-1:0]     root_in, root_nxt;
    logic [RAD_W-1:0] x_in;
    pec_pkg::side_t   side_in;
    logic             ge;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i];
      assign rem_in  = rem_r[i];
      assign root_in = root_r[i];
      assign x_in    = x_r[i];
      assign side_in = side_r[i];
    end

    always_comb begin
      rem_sh   = {rem_in[REM_W-3:0], x_in[RAD_W-1 -: 2]};
      trial    = {root_in, 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_in[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i+1] <= root_nxt;
        side_r[i+1] <= side_in;
      end
    end

    if (i < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= rem_nxt;
          x_r[i+1]   <= {x_in[RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_root = root_r[N];
  assign out_side = side_r[N];

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int POS_W       = pec_pkg::POS_W;
  localparam int YAW_W       = pec_pkg::YAW_W;
  localparam int FEAT_PORT_W = pec_pkg::FEAT_PORT_W;
  localparam int TIME_W      = pec_pkg::TIME_W;
  localparam int PEN_W       = pec_pkg::PEN_W;
  localparam int ADDR_W      = pec_pkg::ADDR_W;
  localparam int DATA_W      = pec_pkg::DATA_W;

  // Every accepted pose pair produces exactly one result transaction.
  // The tail wait is sized from PIPE_LATENCY; the watchdog limit is a separate constant.
  localparam int PIPE_LATENCY   = 33;
  localparam int TAIL_CYCLES    = 2 * PIPE_LATENCY;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PAIRS   = 1050;

  // Fixed-point constants of the cost function.
  localparam longint unsigned TWO_PI_FX    = 411775;
  localparam longint unsigned TIME_CEIL    = 64'hFFFF_FFFF;
  localparam longint unsigned PENALTY_CEIL = 8191;
  localparam logic [31:0]     RECIP_MASK   = 32'h007F_FFFF;
  localparam logic [31:0]     THRESH_MASK  = 32'h0000_007F;

  // Field extremes. Yaws are legal in [-pi, pi], but the port allows the full 19-bit range.
  localparam int POS_HI   = 67108863;
  localparam int POS_LO   = -67108864;
  localparam int YAW_HI   = 262143;
  localparam int YAW_LO   = -262144;
  localparam int YAW_HALF = 205887;

  // An address past the last register. Writes to it must leave every register alone.
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(12);

  typedef struct packed {
    logic [POS_W-1:0]       pos_a_x;
    logic [POS_W-1:0]       pos_a_y;
    logic [POS_W-1:0]       pos_a_z;
    logic [YAW_W-1:0]       yaw_a;
    logic [POS_W-1:0]       pos_b_x;
    logic [POS_W-1:0]       pos_b_y;
    logic [POS_W-1:0]       pos_b_z;
    logic [YAW_W-1:0]       yaw_b;
    logic [FEAT_PORT_W-1:0] features_a;
    logic [FEAT_PORT_W-1:0] features_b;
  } pose_pair_t;

  typedef struct packed {
    logic [TIME_W-1:0] travel_time;
    logic              localizable;
    logic [PEN_W-1:0]  feature_penalty;
  } edge_cost_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid      = 1'b0;
  logic                   in_ready;
  logic [POS_W-1:0]       in_pos_a_x    = '0;
  logic [POS_W-1:0]       in_pos_a_y    = '0;
  logic [POS_W-1:0]       in_pos_a_z    = '0;
  logic [YAW_W-1:0]       in_yaw_a      = '0;
  logic [POS_W-1:0]       in_pos_b_x    = '0;
  logic [POS_W-1:0]       in_pos_b_y    = '0;
  logic [POS_W-1:0]       in_pos_b_z    = '0;
  logic [YAW_W-1:0]       in_yaw_b      = '0;
  logic [FEAT_PORT_W-1:0] in_features_a = '0;
  logic [FEAT_PORT_W-1:0] in_features_b = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [TIME_W-1:0] out_travel_time;
  logic              out_localizable;
  logic [PEN_W-1:0]  out_feature_penalty;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Shadow copy of the configuration registers, loaded with their reset values.
  longint unsigned speed_recip  = 65536;
  longint unsigned yaw_recip    = 65536;
  longint unsigned share_thresh = 10;

  // Costs predicted for accepted pairs, oldest first.
  edge_cost_t cost_due[$];

  int fail_count  = 0;
  int pairs_sent  = 0;
  int idle_cycles = 0;
  int stall_left  = 0;

  // When clear, neither side inserts gaps: the pipeline runs back to back.
  bit idle_en = 1'b1;

  pose_edge_cost_evaluator u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pos_a_x          (in_pos_a_x),
    .in_pos_a_y          (in_pos_a_y),
    .in_pos_a_z          (in_pos_a_z),
    .in_yaw_a            (in_yaw_a),
    .in_pos_b_x          (in_pos_b_x),
    .in_pos_b_y          (in_pos_b_y),
    .in_pos_b_z          (in_pos_b_z),
    .in_yaw_b            (in_yaw_b),
    .in_features_a       (in_features_a),
    .in_features_b       (in_features_b),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_travel_time     (out_travel_time),
    .out_localizable     (out_localizable),
    .out_feature_penalty (out_feature_penalty),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Cost prediction
  // ---------------------------------------------------------------------------------------

  // Square of one coordinate difference. The difference is exact in Q16, so its square
  // is exact in Q32 and fits comfortably in 64 bits.
  function automatic longint unsigned axis_square(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d < 0) d = -d;
    return d * d;
  endfunction

  // Floor of the square root, built one root bit at a time from the top down.
  // The sum of three squares stays below 2^56, so the root needs at most 28 bits.
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 29; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic edge_cost_t predict_edge_cost(pose_pair_t p);
    edge_cost_t      cost;
    longint unsigned path_len;
    longint unsigned yaw_wrap;
    longint unsigned t_path;
    longint unsigned t_yaw;
    longint unsigned t_edge;
    longint unsigned shortfall;
    longint          yaw_gap;
    int unsigned     shared_cnt;
    int unsigned     differ_cnt;

    path_len = floor_sqrt(axis_square(p.pos_a_x, p.pos_b_x) +
                          axis_square(p.pos_a_y, p.pos_b_y) +
                          axis_square(p.pos_a_z, p.pos_b_z));

    // The yaw difference wraps around 2*pi. A gap wider than a full turn can only come
    // from yaws outside [-pi, pi], and the block treats it as no rotation at all.
    yaw_gap = longint'($signed(p.yaw_a)) - longint'($signed(p.yaw_b));
    if (yaw_gap < 0) yaw_gap = -yaw_gap;
    yaw_wrap = yaw_gap;
    if (yaw_wrap > TWO_PI_FX) yaw_wrap = 0;
    else if (TWO_PI_FX - yaw_wrap < yaw_wrap) yaw_wrap = TWO_PI_FX - yaw_wrap;

    // Both products truncate back to Q16.16. A zero reciprocal simply zeroes its term.
    t_path = (path_len * speed_recip) >> 16;
    t_yaw  = (yaw_wrap * yaw_recip) >> 16;
    t_edge = (t_path > t_yaw) ? t_path : t_yaw;
    if (t_edge > TIME_CEIL) t_edge = TIME_CEIL;

    // All 64 feature bits count, since the block is built with its default width.
    shared_cnt = $countones(p.features_a & p.features_b);
    differ_cnt = $countones(p.features_a ^ p.features_b);

    // A threshold above 64 can push the squared shortfall past the 13-bit ceiling.
    shortfall = 0;
    if (differ_cnt < share_thresh) begin
      shortfall = share_thresh - differ_cnt;
      shortfall = shortfall * shortfall;
      if (shortfall > PENALTY_CEIL) shortfall = PENALTY_CEIL;
    end

    cost.travel_time     = t_edge[TIME_W-1:0];
    cost.localizable     = (shared_cnt > share_thresh);
    cost.feature_penalty = shortfall[PEN_W-1:0];
    return cost;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic pose_pair_t pose_pair(int ax, int ay, int az, int ya, int bx, int by,
                                           int bz, int yb, logic [63:0] fa, logic [63:0] fb);
    pose_pair_t p;
    p.pos_a_x    = POS_W'(ax);
    p.pos_a_y    = POS_W'(ay);
    p.pos_a_z    = POS_W'(az);
    p.yaw_a      = YAW_W'(ya);
    p.pos_b_x    = POS_W'(bx);
    p.pos_b_y    = POS_W'(by);
    p.pos_b_z    = POS_W'(bz);
    p.yaw_b      = YAW_W'(yb);
    p.features_a = fa;
    p.features_b = fb;
    return p;
  endfunction

  function automatic logic [63:0] low_bits(int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // A coordinate at a random distance from the given one, anywhere from zero up to 2^26 - 1
  // LSBs, so that short hops and long ones both show up in the distance root.
  function automatic logic [POS_W-1:0] nearby_coord(logic [POS_W-1:0] base);
    logic [POS_W-1:0] delta;
    delta = POS_W'($urandom) & POS_W'(low_bits($urandom_range(0, POS_W - 1)));
    return $urandom_range(0, 1) ? base + delta : base - delta;
  endfunction

  function automatic logic [YAW_W-1:0] random_yaw();
    if ($urandom_range(0, 1)) return YAW_W'($urandom);
    return YAW_W'(int'($urandom_range(0, 2 * YAW_HALF)) - YAW_HALF);
  endfunction

  function automatic pose_pair_t random_pose_pair();
    pose_pair_t  p;
    logic [63:0] fa;
    int          flips;

    p.pos_a_x = POS_W'($urandom);
    p.pos_a_y = POS_W'($urandom);
    p.pos_a_z = POS_W'($urandom);
    case ($urandom_range(0, 3)) inside
      0: begin
        p.pos_b_x = POS_W'($urandom);
        p.pos_b_y = POS_W'($urandom);
        p.pos_b_z = POS_W'($urandom);
      end
      [1:2]: begin
        p.pos_b_x = nearby_coord(p.pos_a_x);
        p.pos_b_y = nearby_coord(p.pos_a_y);
        p.pos_b_z = nearby_coord(p.pos_a_z);
      end
      default: begin
        p.pos_b_x = p.pos_a_x;
        p.pos_b_y = p.pos_a_y;
        p.pos_b_z = p.pos_a_z;
      end
    endcase
    p.yaw_a = random_yaw();
    p.yaw_b = $urandom_range(0, 5) == 0 ? p.yaw_a : random_yaw();

    // Vary the bit density so that shared and differing counts sweep across the threshold.
    case ($urandom_range(0, 3))
      0:       fa = random_word();
      1:       fa = random_word() & random_word();
      2:       fa = random_word() | random_word();
      default: fa = random_word() & random_word() & random_word();
    endcase
    p.features_a = fa;
    case ($urandom_range(0, 3)) inside
      [0:1]: begin
        // A few flipped bits keep the differing count small, where the penalty lives.
        flips = $urandom_range(0, 16);
        for (int i = 0; i < flips; i++) fa[$urandom_range(0, 63)] ^= 1'b1;
        p.features_b = fa;
      end
      2:       p.features_b = fa & random_word();
      default: p.features_b = random_word();
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------------------

  // Sends one pose pair. The pair is predicted at the edge where it is accepted, so the
  // prediction always uses the configuration that the block is running with.
  task automatic send_pose_pair(input pose_pair_t p);
    int gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pos_a_x    <= p.pos_a_x;
    in_pos_a_y    <= p.pos_a_y;
    in_pos_a_z    <= p.pos_a_z;
    in_yaw_a      <= p.yaw_a;
    in_pos_b_x    <= p.pos_b_x;
    in_pos_b_y    <= p.pos_b_y;
    in_pos_b_z    <= p.pos_b_z;
    in_yaw_b      <= p.yaw_b;
    in_features_a <= p.features_a;
    in_features_b <= p.features_b;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    cost_due.insert(cost_due.size(), predict_edge_cost(p));
    pairs_sent++;
  endtask

  // Lowers valid and waits for every outstanding result. Every pair yields a result, so
  // the pipeline is empty once the last one has been taken.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (cost_due.size() != 0);
  endtask

  // One register write: a setup cycle, then the access cycle. pready is tied high, so the
  // write lands at the end of the access cycle. The bus then rests before the task returns.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr[ADDR_W-1:2])
      pec_pkg::REG_INV_SPEED:  speed_recip  = data & RECIP_MASK;
      pec_pkg::REG_INV_YAW:    yaw_recip    = data & RECIP_MASK;
      pec_pkg::REG_MIN_SHARED: share_thresh = data & THRESH_MASK;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] reg_addr(pec_pkg::reg_idx_t idx);
    return ADDR_W'({idx, 2'b00});
  endfunction

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Reset configuration: one second per metre and per radian, threshold of ten features.
  task automatic test_reset_defaults();
    idle_en = 1'b1;
    // Everything zero: no motion, no features, so the whole threshold is a shortfall.
    send_pose_pair(pose_pair(0, 0, 0, 0, 0, 0, 0, 0, '0, '0));
    // Opposite corners of the position space, and a yaw gap wider than a full turn.
    send_pose_pair(pose_pair(POS_HI, POS_HI, POS_HI, YAW_HI, POS_LO, POS_LO, POS_LO, YAW_LO,
                             '1, '1));
    send_pose_pair(pose_pair(POS_LO, POS_LO, POS_LO, YAW_HALF, POS_HI, POS_HI, POS_HI,
                             -YAW_HALF, '1, '0));
    // Yaw gap of exactly one turn wraps to zero.
    send_pose_pair(pose_pair(0, 0, 0, YAW_HALF, 0, 0, 0, -YAW_HALF - 1, '0, '1));
    // Half a turn on either side of the wrap point; shared count equal to, then above,
    // the threshold.
    send_pose_pair(pose_pair(0, 0, 0, YAW_HALF, 0, 0, 0, 0, low_bits(10), low_bits(11)));
    send_pose_pair(pose_pair(0, 0, 0, 0, 0, 0, 0, -YAW_HALF - 1, low_bits(11), low_bits(11)));
    // Differing count one short of, then equal to, the threshold.
    send_pose_pair(pose_pair(1, 0, 0, 0, 0, 0, 0, 0, low_bits(9), '0));
    send_pose_pair(pose_pair(3 << 16, 4 << 16, 12 << 16, 0, 0, 0, 0, 0, low_bits(10), '0));
    // Short hop with a large turn: the yaw term decides.
    send_pose_pair(pose_pair(100, -100, 7, -100000, 0, 0, 0, 100000, random_word(),
                             random_word()));
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    idle_en = 1'b0;
    // Largest reciprocals: the path term overflows 32 bits and must saturate. A threshold
    // of 127 squares past the penalty ceiling.
    write_reg(reg_addr(pec_pkg::REG_INV_SPEED), RECIP_MASK);
    write_reg(reg_addr(pec_pkg::REG_INV_YAW), RECIP_MASK);
    write_reg(reg_addr(pec_pkg::REG_MIN_SHARED), THRESH_MASK);
    send_pose_pair(pose_pair(POS_HI, POS_HI, POS_HI, YAW_HI, POS_LO, POS_LO, POS_LO, YAW_LO,
                             '1, '1));
    send_pose_pair(pose_pair(0, 0, 0, YAW_HALF, 0, 0, 0, 0, '0, '0));
    drain_pipeline();

    // Zero speed reciprocal removes the path term; a threshold of 64 equals the full
    // feature width.
    write_reg(reg_addr(pec_pkg::REG_INV_SPEED), '0);
    write_reg(reg_addr(pec_pkg::REG_MIN_SHARED), 64);
    send_pose_pair(pose_pair(POS_HI, POS_HI, POS_HI, 0, POS_LO, POS_LO, POS_LO, 0, '1, '1));
    send_pose_pair(pose_pair(POS_LO, 0, POS_HI, -YAW_HALF, POS_HI, 0, POS_LO, YAW_HALF,
                             '1, 64'hFFFF_FFFF_FFFF_FFFE));
    drain_pipeline();

    // Smallest reciprocal and a zero threshold: any shared feature makes the pair usable.
    write_reg(reg_addr(pec_pkg::REG_INV_YAW), '0);
    write_reg(reg_addr(pec_pkg::REG_INV_SPEED), 1);
    write_reg(reg_addr(pec_pkg::REG_MIN_SHARED), '0);
    send_pose_pair(pose_pair(POS_HI, POS_HI, POS_HI, YAW_HALF, POS_LO, POS_LO, POS_LO, 0,
                             64'h1, 64'h1));
    send_pose_pair(pose_pair(0, 0, 0, 0, 0, 0, 0, 0, '0, '0));
    drain_pipeline();

    // Bits above each register's width are dropped, and a write past the last register
    // changes nothing.
    write_reg(reg_addr(pec_pkg::REG_INV_SPEED), 32'hFF80_0000 | 32'd65536);
    write_reg(reg_addr(pec_pkg::REG_INV_YAW), 32'hFF80_0000 | 32'd32768);
    write_reg(reg_addr(pec_pkg::REG_MIN_SHARED), 32'hFFFF_FF80 | 32'd10);
    write_reg(ADDR_UNMAPPED, '1);
    send_pose_pair(pose_pair(5 << 16, 0, 0, 150000, 0, 0, 0, -150000, low_bits(12),
                             low_bits(4)));
    drain_pipeline();
  endtask

  function automatic logic [DATA_W-1:0] random_recip();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 1;
      2:       return RECIP_MASK;
      3:       return $urandom_range(1, 6553600);
      default: return $urandom_range(4096, 262144);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_thresh();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 64;
      2:       return $urandom_range(65, 127);
      default: return $urandom_range(0, 64);
    endcase
  endfunction

  // Random pose pairs in phases. Each phase runs under a fresh configuration, written
  // while the pipeline is empty; some phases run with no gaps on either side.
  task automatic test_random_traffic();
    int          phase_len;
    logic [31:0] junk;
    while (pairs_sent < RANDOM_PAIRS) begin
      junk = $urandom_range(0, 3) == 0 ? $urandom : 32'h0;
      write_reg(reg_addr(pec_pkg::REG_INV_SPEED), (junk & ~RECIP_MASK) | random_recip());
      write_reg(reg_addr(pec_pkg::REG_INV_YAW), (junk & ~RECIP_MASK) | random_recip());
      write_reg(reg_addr(pec_pkg::REG_MIN_SHARED), (junk & ~THRESH_MASK) | random_thresh());
      if ($urandom_range(0, 7) == 0) write_reg(ADDR_UNMAPPED, $urandom);
      idle_en   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(40, 120);
      if (phase_len > RANDOM_PAIRS - pairs_sent) phase_len = RANDOM_PAIRS - pairs_sent;
      repeat (phase_len) send_pose_pair(random_pose_pair());
      drain_pipeline();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checking and output back-pressure
  // ---------------------------------------------------------------------------------------

  // Each accepted result transaction is compared with the oldest prediction. After each
  // one the receiver may drop ready for a random stall while idle_en is set.
  always @(posedge clk) begin : result_check
    edge_cost_t want;
    int         stall;
    if (!rst_n) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (cost_due.size() == 0) begin
        $display("%0t: result transaction with nothing expected: time %0d loc %0d pen %0d",
                 $time, out_travel_time, out_localizable, out_feature_penalty);
        fail_count++;
      end else begin
        want = cost_due.pop_front();
        if (out_travel_time !== want.travel_time) begin
          $display("%0t: travel_time mismatch: expected %0d, actual %0d", $time,
                   want.travel_time, out_travel_time);
          fail_count++;
        end
        if (out_localizable !== want.localizable) begin
          $display("%0t: localizable mismatch: expected %0d, actual %0d", $time,
                   want.localizable, out_localizable);
          fail_count++;
        end
        if (out_feature_penalty !== want.feature_penalty) begin
          $display("%0t: feature_penalty mismatch: expected %0d, actual %0d", $time,
                   want.feature_penalty, out_feature_penalty);
          fail_count++;
        end
      end
      stall = idle_en ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall;
      end
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready <= 1'b1;
    end
  end

  // The watchdog ends the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time, cost_due.size());
      $display("pose_edge_cost_evaluator regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    drain_pipeline();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && cost_due.size() == 0) begin
      $display("pose_edge_cost_evaluator regression: pass");
    end else begin
      $display("pose_edge_cost_evaluator regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pec_pkg.sv
rtl/core/pec_front.sv
rtl/core/pec_isqrt.sv
rtl/core/pose_edge_cost_evaluator.sv
test/tb.sv
